// ===== sv/srp_pkg.sv =====
// Package: widths, types and constants shared by the root-per-prime block.
package srp_pkg;
  localparam int WORD_BITS = 32;
  localparam int ROOT_BITS = 31;
  localparam int HALF_BITS = 24;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
  localparam logic [HALF_BITS-1:0] HALF_SIEVE_RESET = HALF_BITS'(32768);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t                prime;
    word_t                a_residue;
    word_t                b_residue;
    logic [ROOT_BITS-1:0] root_of_n;
    logic                 last_prime;
  } in_req_t;

  typedef struct packed {
    word_t a_inverse;
    word_t root_low;
    word_t root_high;
    logic  no_inverse;
    logic  last_root;
  } out_req_t;

  // a, b < p
  function automatic word_t add_mod(word_t a, word_t b, word_t p);
    logic [WORD_BITS:0] s;
    logic [WORD_BITS:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, p};
    return (s >= {1'b0, p}) ? d[WORD_BITS-1:0] : s[WORD_BITS-1:0];
  endfunction

  function automatic word_t sub_mod(word_t a, word_t b, word_t p);
    return (a >= b) ? a - b : a + (p - b);
  endfunction
endpackage

// ===== sv/srp_if.sv =====
// Handshake interfaces for the request and result channels.
interface srp_in_if (input logic clk);
  import srp_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srp_out_if (input logic clk);
  import srp_pkg::*;
  logic     valid;
  logic     ready;
  out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sieve_root_per_prime.sv =====
// Top level: per-prime sieve root computation with a small sequencer.
// Each divider or multiplier run goes through start, 32 bit steps, then done.
// Euclid takes at most 45 steps for a 32-bit prime; with no inverse the final
// multiplications are skipped, and a prime below two goes straight to the
// result. One item at a time: ready again the cycle after the result register
// loads, later if the previous result waits.
// Reset (synchronous, rst_n low) idles the sequencer, half_sieve = 32768.
module sieve_root_per_prime (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [srp_pkg::HALF_BITS-1:0]   cfg_wdata,
  srp_in_if.sink                          in_ch,
  srp_out_if.source                       out_ch
);
  import srp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RA    = 11'b00000000010,
    S_RB    = 11'b00000000100,
    S_RS    = 11'b00000001000,
    S_RH    = 11'b00000010000,
    S_EDIV  = 11'b00000100000,
    S_EMUL  = 11'b00001000000,
    S_M1    = 11'b00010000000,
    S_M2    = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t  state_r, state_nxt;
  logic [HALF_BITS-1:0] half_r;
  word_t   p_r, p_nxt, a_r, a_nxt, b_r, b_nxt, s_r, s_nxt, h_r, h_nxt;
  word_t   r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  word_t   q_r, q_nxt, m1_r, m1_nxt;
  logic    last_r, last_nxt;
  logic    wait_r, wait_nxt;
  out_req_t res_r, res_nxt;
  logic    ovalid_r, ovalid_nxt;

  logic    dv_start, dv_done, ml_start, ml_done;
  word_t   dv_num, dv_den, dv_quo, dv_rem, ml_a, ml_b, ml_prod;
  word_t   r1s, r2s, tt;

  srp_divmod u_div (.clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
                    .done(dv_done), .quo(dv_quo), .rem(dv_rem));
  srp_mulmod u_mul (.clk, .rst_n, .start(ml_start), .a(ml_a), .b(ml_b), .p(p_r),
                    .done(ml_done), .prod(ml_prod));

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) half_r <= HALF_SIEVE_RESET;
    else if (cfg_we) half_r <= cfg_wdata;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    p_nxt = p_r; a_nxt = a_r; b_nxt = b_r; s_nxt = s_r; h_nxt = h_r;
    r0_nxt = r0_r; r1_nxt = r1_r; t0_nxt = t0_r; t1_nxt = t1_r;
    q_nxt = q_r; m1_nxt = m1_r; last_nxt = last_r;
    wait_nxt = 1'b0;
    res_nxt = res_r; ovalid_nxt = ovalid_r;
    dv_start = 1'b0; dv_num = a_r; dv_den = p_r;
    ml_start = 1'b0; ml_a = q_r; ml_b = t1_r;
    tt  = add_mod(m1_r, m1_r, p_r);
    r1s = add_mod(q_r, h_r, p_r);
    r2s = sub_mod(r1s, tt, p_r);
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          p_nxt = in_ch.data.prime;
          a_nxt = in_ch.data.a_residue;
          b_nxt = in_ch.data.b_residue;
          s_nxt = WORD_BITS'(in_ch.data.root_of_n);
          last_nxt = in_ch.data.last_prime;
          wait_nxt = 1'b1;
          state_nxt = (in_ch.data.prime < WORD_BITS'(2)) ? S_FIN : S_RA;
          r0_nxt = WORD_BITS'(0);
        end
      end
      S_RA: begin
        dv_num = a_r; dv_start = wait_r;
        if (dv_done) begin a_nxt = dv_rem; wait_nxt = 1'b1; state_nxt = S_RB; end
      end
      S_RB: begin
        dv_num = b_r; dv_start = wait_r;
        if (dv_done) begin b_nxt = dv_rem; wait_nxt = 1'b1; state_nxt = S_RS; end
      end
      S_RS: begin
        dv_num = s_r; dv_start = wait_r;
        if (dv_done) begin s_nxt = dv_rem; wait_nxt = 1'b1; state_nxt = S_RH; end
      end
      S_RH: begin
        dv_num = WORD_BITS'(half_r); dv_start = wait_r;
        if (dv_done) begin
          h_nxt = dv_rem;
          r0_nxt = p_r; r1_nxt = a_r; t0_nxt = '0; t1_nxt = WORD_BITS'(1);
          wait_nxt = 1'b1;
          state_nxt = S_EDIV;
        end
      end
      S_EDIV: begin
        if (r1_r == '0) begin
          state_nxt = S_FIN;
          if (r0_r == WORD_BITS'(1)) begin
            wait_nxt = 1'b1;
            state_nxt = S_M1;
          end
        end else begin
          dv_num = r0_r; dv_den = r1_r; dv_start = wait_r;
          if (dv_done) begin
            q_nxt = dv_quo;  // quotient <= p; a quotient of p adds zero in the multiplier
            r0_nxt = r1_r; r1_nxt = dv_rem;
            wait_nxt = 1'b1;
            state_nxt = S_EMUL;
          end
        end
      end
      S_EMUL: begin
        ml_a = q_r; ml_b = t1_r; ml_start = wait_r;
        if (ml_done) begin
          t0_nxt = t1_r; t1_nxt = sub_mod(t0_r, ml_prod, p_r);
          wait_nxt = 1'b1;
          state_nxt = S_EDIV;
        end
      end
      S_M1: begin
        ml_a = sub_mod(s_r, b_r, p_r); ml_b = t0_r; ml_start = wait_r;
        if (ml_done) begin q_nxt = ml_prod; wait_nxt = 1'b1; state_nxt = S_M2; end
      end
      S_M2: begin
        ml_a = s_r; ml_b = t0_r; ml_start = wait_r;
        if (ml_done) begin m1_nxt = ml_prod; r0_nxt = WORD_BITS'(1); state_nxt = S_FIN; end
      end
      S_FIN: begin
        if (!ovalid_r || out_ch.ready) begin
          res_nxt.last_root = last_r;
          if (r0_r == WORD_BITS'(1) && p_r >= WORD_BITS'(2)) begin
            res_nxt.a_inverse  = t0_r;
            res_nxt.root_low   = (r1s <= r2s) ? r1s : r2s;
            res_nxt.root_high  = (r1s <= r2s) ? r2s : r1s;
            res_nxt.no_inverse = 1'b0;
          end else begin
            res_nxt.a_inverse  = '0;
            res_nxt.root_low   = '0;
            res_nxt.root_high  = '0;
            res_nxt.no_inverse = 1'b1;
          end
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      wait_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      wait_r   <= wait_nxt;
    end
    p_r <= p_nxt; a_r <= a_nxt; b_r <= b_nxt; s_r <= s_nxt; h_r <= h_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt;
    q_r <= q_nxt; m1_r <= m1_nxt; last_r <= last_nxt; res_r <= res_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("accept did not start work");
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && res_r.no_inverse) |-> (res_r.a_inverse == '0))
    else $error("flagged result with inverse");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (res_r.root_low <= res_r.root_high))
    else $error("roots out of order");
endmodule

// ===== sv/srp_divmod.sv =====
// Restoring divider: one quotient bit per cycle, also used for reductions.
module srp_divmod (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  srp_pkg::word_t  num,
  input  srp_pkg::word_t  den,
  output logic            done,
  output srp_pkg::word_t  quo,
  output srp_pkg::word_t  rem
);
  import srp_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  word_t                q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic                 done_r, done_nxt;
  logic [WORD_BITS:0]   trial;

  // one shift-subtract step
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    done_nxt = 1'b0;
    trial    = {r_r, q_r[WORD_BITS-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(WORD_BITS);
      q_nxt    = num;
      r_nxt    = '0;
      d_nxt    = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = WORD_BITS'(trial - {1'b0, d_r});
        q_nxt = {q_r[WORD_BITS-2:0], 1'b1};
      end else begin
        r_nxt = trial[WORD_BITS-1:0];
        q_nxt = {q_r[WORD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
endmodule

// ===== sv/srp_mulmod.sv =====
// Shift-and-add modular multiplier, one operand bit per cycle.
module srp_mulmod (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  srp_pkg::word_t  a,
  input  srp_pkg::word_t  b,
  input  srp_pkg::word_t  p,
  output logic            done,
  output srp_pkg::word_t  prod
);
  import srp_pkg::*;

  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  word_t               acc_r, acc_nxt, a_r, a_nxt, b_r, b_nxt, p_r, p_nxt;
  word_t               dbl;

  // acc = 2*acc (+a) mod p, MSB first
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    dbl      = add_mod(acc_r, acc_r, p_r);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(WORD_BITS);
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      p_nxt    = p;
    end else if (busy_r) begin
      acc_nxt = b_r[WORD_BITS-1] ? add_mod(dbl, a_r, p_r) : dbl;
      b_nxt   = {b_r[WORD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    p_r   <= p_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

  a_mul_below_p: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < p_r)) else $error("product not reduced");
endmodule
